// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PCU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pcu_pkg.sv
// ---------------------------------------------------------------------------
// pcu_pkg
// Shared codes, command/status structs and the factorial table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcu_pkg;

  localparam int unsigned MAX_FACT_ARG_DEF = 20;

  localparam logic [1:0] OP_PERM     = 2'd0;
  localparam logic [1:0] OP_POW      = 2'd1;
  localparam logic [1:0] OP_COMB     = 2'd2;
  localparam logic [1:0] OP_COMB_REP = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_R_GT_N = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;
  localparam logic [1:0] ST_OVF    = 2'd3;

  typedef struct packed {
    logic load;
    logic init;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic emit;
  } pcu_cmd_t;

  typedef struct packed {
    logic early;
    logic mul_done;
    logic need_div;
    logic div_last;
  } pcu_sts_t;

  function automatic logic [63:0] fact_tab(input logic [4:0] a);
    logic [63:0] f;
    unique case (a)
      5'd0:    f = 64'd1;
      5'd1:    f = 64'd1;
      5'd2:    f = 64'd2;
      5'd3:    f = 64'd6;
      5'd4:    f = 64'd24;
      5'd5:    f = 64'd120;
      5'd6:    f = 64'd720;
      5'd7:    f = 64'd5040;
      5'd8:    f = 64'd40320;
      5'd9:    f = 64'd362880;
      5'd10:   f = 64'd3628800;
      5'd11:   f = 64'd39916800;
      5'd12:   f = 64'd479001600;
      5'd13:   f = 64'd6227020800;
      5'd14:   f = 64'd87178291200;
      5'd15:   f = 64'd1307674368000;
      5'd16:   f = 64'd20922789888000;
      5'd17:   f = 64'd355687428096000;
      5'd18:   f = 64'd6402373705728000;
      5'd19:   f = 64'd121645100408832000;
      5'd20:   f = 64'd2432902008176640000;
      default: f = 64'd2432902008176640000;
    endcase
    return f;
  endfunction

endpackage

// File: hw/rtl/pcu_ctrl.sv
// ---------------------------------------------------------------------------
// pcu_ctrl
// Sequencer: setup, multiply loop, bit-serial divide, result strobe.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcu_ctrl
  import pcu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output pcu_cmd_t cmd,
  input  pcu_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:  cmd.load = start;
      S_SETUP: cmd.init = 1'b1;
      S_MUL: begin
        cmd.mul_step = !sts.mul_done;
        cmd.div_init = sts.mul_done && sts.need_div;
      end
      S_DIV:   cmd.div_step = 1'b1;
      S_DONE:  cmd.emit = 1'b1;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_DONE);
      unique case (state_r)
        S_IDLE:  if (start) state_r <= S_SETUP;
        S_SETUP: state_r <= sts.early ? S_DONE : S_MUL;
        S_MUL: begin
          if (sts.mul_done) state_r <= sts.need_div ? S_DIV : S_DONE;
        end
        S_DIV:   if (sts.div_last) state_r <= S_DONE;
        S_DONE:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/pcu_dp.sv
// ---------------------------------------------------------------------------
// pcu_dp
// Operand registers, 64x16 product loop and restoring divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcu_dp
  import pcu_pkg::*;
#(
  parameter int unsigned MAX_FACT_ARG = MAX_FACT_ARG_DEF
) (
  input  logic        clk,
  input  pcu_cmd_t    cmd,
  output pcu_sts_t    sts,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_n,
  input  logic [7:0]  in_r,
  output logic [63:0] out_count,
  output logic [1:0]  out_status
);

  localparam logic [15:0] MaxN = 16'(MAX_FACT_ARG);

  logic [1:0]  op_r;
  logic [15:0] n_r;
  logic [7:0]  r_r;
  logic [63:0] acc_r;
  logic [15:0] term_r;
  logic [7:0]  cnt_r;
  logic [1:0]  stat_r;
  logic [63:0] rem_r;
  logic [63:0] dvs_r;
  logic [5:0]  dcnt_r;
  logic [63:0] out_count_r;
  logic [1:0]  out_status_r;

  logic [16:0] rep_top;
  logic        early;
  logic [1:0]  early_st;
  logic [63:0] early_cnt;
  logic [79:0] prod;
  logic [63:0] shifted;
  logic        qbit;

  // largest factorial argument for combinations with repetition: n+r-1
  assign rep_top = {1'b0, n_r} + 17'(r_r) - 17'd1;

  always_comb begin
    early     = 1'b0;
    early_st  = ST_OK;
    early_cnt = 64'd0;
    unique case (op_r)
      OP_PERM, OP_COMB: begin
        if (16'(r_r) > n_r) begin
          early    = 1'b1;
          early_st = ST_R_GT_N;
        end else if (n_r > MaxN) begin
          early    = 1'b1;
          early_st = ST_OVF;
        end
      end
      OP_POW: early = 1'b0;
      OP_COMB_REP: begin
        if (n_r == 16'd0) begin
          early = 1'b1;
          if (r_r == 8'd0) early_cnt = 64'd1;
          else             early_st  = ST_NONE;
        end else if (rep_top > {1'b0, MaxN}) begin
          early    = 1'b1;
          early_st = ST_OVF;
        end
      end
      default: early = 1'b0;
    endcase
  end

  assign prod    = {16'd0, acc_r} * {64'd0, term_r};
  assign shifted = {rem_r[62:0], acc_r[63]};
  assign qbit    = (shifted >= dvs_r);

  assign sts.early    = early;
  assign sts.mul_done = (cnt_r == 8'd0);
  assign sts.need_div = (op_r == OP_COMB) || (op_r == OP_COMB_REP);
  assign sts.div_last = (dcnt_r == 6'd0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      n_r  <= in_n;
      r_r  <= in_r;
    end
    if (cmd.init) begin
      cnt_r  <= r_r;
      acc_r  <= early ? early_cnt : 64'd1;
      stat_r <= early ? early_st : ST_OK;
      // first factor: n for power and repetition, n-r+1 otherwise
      if (op_r == OP_POW || op_r == OP_COMB_REP) term_r <= n_r;
      else                                       term_r <= n_r - 16'(r_r) + 16'd1;
    end
    if (cmd.mul_step) begin
      acc_r <= prod[63:0];
      cnt_r <= cnt_r - 8'd1;
      if (op_r != OP_POW) term_r <= term_r + 16'd1;
      if (prod[79:64] != 16'd0) stat_r <= ST_OVF;
    end
    if (cmd.div_init) begin
      rem_r  <= 64'd0;
      dcnt_r <= 6'd63;
      dvs_r  <= fact_tab(r_r[4:0]);
    end
    if (cmd.div_step) begin
      rem_r  <= qbit ? (shifted - dvs_r) : shifted;
      acc_r  <= {acc_r[62:0], qbit};
      dcnt_r <= dcnt_r - 6'd1;
    end
    if (cmd.emit) begin
      out_count_r  <= acc_r;
      out_status_r <= stat_r;
    end
  end

  assign out_count  = out_count_r;
  assign out_status = out_status_r;

endmodule

// File: hw/rtl/permutation_combination_unit_core.sv
// ---------------------------------------------------------------------------
// permutation_combination_unit_core
// Counting unit: P(n,r), n^r, C(n,r) and C(n+r-1,r), one item at a time.
// ---------------------------------------------------------------------------
//  channel  | ports                          | handshake
//  ---------+--------------------------------+------------------------------
//  input    | in_opcode, in_n, in_r          | taken when start && !busy
//  result   | out_count, out_status          | out_valid, one cycle, no stall
//
//  Error and trivial cases go straight to the strobe. Permutations and powers
//  take one multiply step per factor (r up to 255); combinations then also
//  divide. The work is done by the shared 64x16 multiplier, one factor per
//  cycle, and the 64-step restoring divider, one quotient bit per cycle.
//  Reset clears the sequencer only. The receiver cannot stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module permutation_combination_unit_core
  import pcu_pkg::*;
#(
  parameter int unsigned MAX_FACT_ARG = MAX_FACT_ARG_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_n,
  input  logic [7:0]  in_r,
  output logic        out_valid,
  output logic [63:0] out_count,
  output logic [1:0]  out_status
);

  pcu_cmd_t cmd;
  pcu_sts_t sts;

  pcu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  pcu_dp #(
    .MAX_FACT_ARG (MAX_FACT_ARG)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .sts        (sts),
    .in_opcode  (in_opcode),
    .in_n       (in_n),
    .in_r       (in_r),
    .out_count  (out_count),
    .out_status (out_status)
  );

endmodule

// File: hw/rtl/pcu_chk.sv
// ---------------------------------------------------------------------------
// pcu_chk
// Port-level checks on the counting unit, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcu_chk
  import pcu_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [63:0] out_count,
  input logic [1:0]  out_status
);

  `PCU_ASSERT_NXT(a_take_busy, clk, rst_n, start && !busy, busy, "item taken but not busy")
  `PCU_ASSERT_IMP(a_done_strobe, clk, rst_n, $fell(busy), out_valid, "busy fell without result")
  `PCU_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid, !busy, "result while still busy")
  `PCU_ASSERT_NXT(a_strobe_once, clk, rst_n, out_valid, !out_valid, "result strobe held")
  `PCU_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && (out_status == ST_R_GT_N || out_status == ST_NONE), out_count == 64'd0, "error with nonzero count")

endmodule

bind permutation_combination_unit_core pcu_chk u_pcu_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_count  (out_count),
  .out_status (out_status)
);

// File: test/permutation_combination_unit_checker.sv
// ---------------------------------------------------------------------------
// permutation_combination_unit_checker
// Watches both channels of the counting unit. Every accepted item is turned
// into an expected count and status by an independent model. Each result
// strobe is compared with the oldest expectation. The failure count and the
// number of items still owed are passed to the testbench top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module permutation_combination_unit_checker
  import pcu_pkg::*;
#(
  parameter int unsigned MAX_FACT_ARG = MAX_FACT_ARG_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_n,
  input  logic [7:0]  in_r,
  input  logic        out_valid,
  input  logic [63:0] out_count,
  input  logic [1:0]  out_status,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  typedef struct {
    logic [1:0]  opcode;
    logic [15:0] n;
    logic [7:0]  r;
    logic [63:0] count;
    logic [1:0]  status;
  } count_expect_t;

  count_expect_t owed_counts[$];
  int unsigned   fails = 0;

  function automatic logic [63:0] factorial(input int unsigned a);
    logic [63:0] f;
    int unsigned i;
    f = 64'd1;
    for (i = 2; i <= a; i++) f = f * 64'(i);
    return f;
  endfunction

  function automatic count_expect_t predict_count(input logic [1:0] op,
                                                  input logic [15:0] n,
                                                  input logic [7:0] r);
    count_expect_t e;
    logic [63:0]   acc;
    logic [127:0]  wide;
    logic          ovf;
    int unsigned   nn;
    int unsigned   rr;
    int unsigned   i;
    nn       = 32'(n);
    rr       = 32'(r);
    e.opcode = op;
    e.n      = n;
    e.r      = r;
    e.count  = 64'd0;
    e.status = ST_OK;
    case (op)
      OP_PERM, OP_COMB: begin
        if (rr > nn) begin
          e.status = ST_R_GT_N;
        end else if (nn > MAX_FACT_ARG) begin
          e.status = ST_OVF;
        end else if (op == OP_PERM) begin
          e.count = factorial(nn) / factorial(nn - rr);
        end else begin
          e.count = factorial(nn) / (factorial(rr) * factorial(nn - rr));
        end
      end
      OP_POW: begin
        acc = 64'd1;
        ovf = 1'b0;
        // true product kept to 128 bits, so anything above 64 bits is overflow
        for (i = 0; i < rr; i++) begin
          wide = {64'd0, acc} * {112'd0, n};
          if (wide[127:64] != 64'd0) ovf = 1'b1;
          acc = wide[63:0];
        end
        e.count  = acc;
        e.status = ovf ? ST_OVF : ST_OK;
      end
      default: begin
        if (nn == 0) begin
          if (rr == 0) e.count = 64'd1;
          else e.status = ST_NONE;
        end else if (nn + rr - 1 > MAX_FACT_ARG) begin
          e.status = ST_OVF;
        end else begin
          e.count = factorial(nn + rr - 1) / (factorial(rr) * factorial(nn - 1));
        end
      end
    endcase
    return e;
  endfunction

  always @(posedge clk) begin : watch
    count_expect_t e;
    if (rst_n) begin
      // a result never belongs to the item taken at the same edge
      if (out_valid) begin
        if (owed_counts.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%t: result with nothing owed: count %0d status %0d",
                     $realtime, out_count, out_status);
        end else begin
          e = owed_counts.pop_front();
          if (out_count !== e.count || out_status !== e.status) begin
            fails++;
            if (fails <= 10)
              $display("%t: mismatch op %0d n %0d r %0d: ",
                       $realtime, e.opcode, e.n, e.r,
                       "count exp %0d got %0d, status exp %0d got %0d",
                       e.count, out_count, e.status, out_status);
          end
        end
      end
      if (start && !busy) owed_counts.push_back(predict_count(in_opcode, in_n, in_r));
    end
    fail_count  <= fails;
    outstanding <= owed_counts.size();
  end

endmodule

// File: test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Testbench top for the counting unit. Sends a directed set of corner items
// for all four counts, then random requests biased towards the small sizes
// where results are exact, with random gaps and one gap-free stretch.
// Checking is left to the checker; this module gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pcu_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1125;
  localparam int unsigned QUIET_LIMIT  = 4000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic [1:0]  in_opcode = OP_PERM;
  logic [15:0] in_n      = 16'd0;
  logic [7:0]  in_r      = 8'd0;
  logic        busy;
  logic        out_valid;
  logic [63:0] out_count;
  logic [1:0]  out_status;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  permutation_combination_unit_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_opcode  (in_opcode),
    .in_n       (in_n),
    .in_r       (in_r),
    .out_valid  (out_valid),
    .out_count  (out_count),
    .out_status (out_status)
  );

  permutation_combination_unit_checker #(
    .MAX_FACT_ARG (MAX_FACT_ARG_DEF)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_opcode   (in_opcode),
    .in_n        (in_n),
    .in_r        (in_r),
    .out_valid   (out_valid),
    .out_count   (out_count),
    .out_status  (out_status),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // rest step: start low and junk on the item ports until the next clock edge
  task automatic rest_cycle();
    start     <= 1'b0;
    in_opcode <= 2'($urandom);
    in_n      <= 16'($urandom);
    in_r      <= 8'($urandom);
    @(posedge clk);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [15:0] n,
                           input logic [7:0] r, input bit may_rest);
    int unsigned gap;
    if (may_rest && $urandom_range(99) < 37) begin
      gap = $urandom_range(1, 270);
      repeat (gap) rest_cycle();
    end
    start     <= 1'b1;
    in_opcode <= op;
    in_n      <= n;
    in_r      <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [1:0]  op;
    logic [15:0] n;
    logic [7:0]  r;
    int unsigned k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_PERM, 16'd0, 8'd0, 1'b1);
    send_item(OP_PERM, 16'd20, 8'd20, 1'b1);
    send_item(OP_PERM, 16'd20, 8'd0, 1'b1);
    send_item(OP_PERM, 16'd21, 8'd1, 1'b1);
    send_item(OP_PERM, 16'd7, 8'd8, 1'b1);
    send_item(OP_PERM, 16'd65535, 8'd255, 1'b1);
    send_item(OP_POW, 16'd0, 8'd0, 1'b1);
    send_item(OP_POW, 16'd0, 8'd255, 1'b1);
    send_item(OP_POW, 16'd65535, 8'd0, 1'b1);
    send_item(OP_POW, 16'd1, 8'd255, 1'b1);
    send_item(OP_POW, 16'd3, 8'd40, 1'b1);
    send_item(OP_POW, 16'd3, 8'd41, 1'b1);
    send_item(OP_POW, 16'd2, 8'd64, 1'b1);
    send_item(OP_POW, 16'd65535, 8'd255, 1'b1);
    send_item(OP_COMB, 16'd20, 8'd10, 1'b1);
    send_item(OP_COMB, 16'd0, 8'd0, 1'b1);
    send_item(OP_COMB, 16'd254, 8'd255, 1'b1);
    send_item(OP_COMB, 16'd21, 8'd0, 1'b1);
    send_item(OP_COMB_REP, 16'd0, 8'd0, 1'b1);
    send_item(OP_COMB_REP, 16'd0, 8'd255, 1'b1);
    send_item(OP_COMB_REP, 16'd1, 8'd20, 1'b1);
    send_item(OP_COMB_REP, 16'd1, 8'd21, 1'b1);
    send_item(OP_COMB_REP, 16'd21, 8'd0, 1'b1);
    send_item(OP_COMB_REP, 16'd22, 8'd0, 1'b1);
    send_item(OP_COMB_REP, 16'd11, 8'd10, 1'b1);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      op = 2'($urandom_range(3));
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: n = 16'($urandom_range(22));
        6, 7:             n = 16'($urandom_range(70));
        default:          n = 16'($urandom);
      endcase
      if ($urandom_range(9) < 6) r = 8'($urandom_range(22));
      else r = 8'($urandom);
      if (k == 300) drain();
      send_item(op, n, r, !(k >= 500 && k < 700));
    end

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pcu_pkg.sv
hw/rtl/pcu_ctrl.sv
hw/rtl/pcu_dp.sv
hw/rtl/permutation_combination_unit_core.sv
hw/rtl/pcu_chk.sv
test/permutation_combination_unit_checker.sv
test/tb.sv
